>>> design/prfl_pkg.sv
`default_nettype none

package prfl_pkg;

    localparam int unsigned PAGE_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned FIU_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [FIU_W-1:0]   FIU_RESET = 5'd4;

    typedef enum logic {
        CFG_POLICY_MODE   = 1'b0,
        CFG_FRAMES_IN_USE = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } t_policy;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              last_in_trace;
    } t_in_beat;

    typedef struct packed {
        logic               hit;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] fault_total;
        logic               trace_end;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_MATCH  = 2'd1,
        ST_UPDATE = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic match;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

>>> design/prfl_ctrl.sv
`default_nettype none

module prfl_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire prfl_pkg::t_dp_status i_status,
    output prfl_pkg::t_dp_cmd        o_cmd
);

    prfl_pkg::t_state r_state;
    prfl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prfl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            prfl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = prfl_pkg::ST_MATCH;
                end
            end
            prfl_pkg::ST_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = prfl_pkg::ST_UPDATE;
            end
            prfl_pkg::ST_UPDATE: begin
                if (i_status.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = prfl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = prfl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/prfl_dp.sv
`default_nettype none

module prfl_dp #(
    parameter int unsigned MAX_FRAMES = 16,
    parameter int unsigned PAGE_BITS  = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire prfl_pkg::t_in_beat                  i_in,
    output prfl_pkg::t_out_beat                      o_out,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    input  wire logic                                i_cfg_we,
    input  wire prfl_pkg::t_cfg_idx                  i_cfg_idx,
    input  wire logic [prfl_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire prfl_pkg::t_dp_cmd                   i_cmd,
    output prfl_pkg::t_dp_status                     o_status
);

    localparam int unsigned SW = (PAGE_BITS < prfl_pkg::PAGE_W) ? PAGE_BITS : prfl_pkg::PAGE_W;
    localparam int unsigned IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned NW = $clog2(MAX_FRAMES + 1);

    prfl_pkg::t_policy                r_policy;
    logic [prfl_pkg::FIU_W-1:0]       r_frames;
    logic [SW-1:0]                    r_page;
    logic                             r_last;
    logic                             r_hit;
    logic [IW-1:0]                    r_slot;
    logic [SW-1:0]                    r_frame_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]            r_frame_valid;
    logic [prfl_pkg::COUNT_W-1:0]     r_count;
    prfl_pkg::t_out_beat              r_out;
    logic                             r_out_valid;

    logic [NW-1:0]                    n_active;
    logic [MAX_FRAMES-1:0]            n_match;
    logic                             n_hit;
    logic [IW-1:0]                    n_slot;
    logic [SW-1:0]                    n_frame_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]            n_frame_valid;
    logic [prfl_pkg::COUNT_W-1:0]     n_count;
    logic                             n_shift;
    logic [IW-1:0]                    n_first;

    always_comb begin
        if (r_frames == '0) begin
            n_active = NW'(1);
        end else if (int'(r_frames) > int'(MAX_FRAMES)) begin
            n_active = NW'(MAX_FRAMES);
        end else begin
            n_active = NW'(r_frames);
        end
    end

    always_comb begin
        n_hit  = 1'b0;
        n_slot = '0;
        for (int j = 0; j < int'(MAX_FRAMES); j++) begin
            n_match[j] = r_frame_valid[j] && (r_frame_page[j] == r_page)
                         && (j < int'(n_active));
        end
        for (int j = int'(MAX_FRAMES) - 1; j >= 0; j--) begin
            if (n_match[j]) begin
                n_hit  = 1'b1;
                n_slot = IW'(j);
            end
        end
    end

    always_comb begin
        n_shift = !r_hit || (r_policy == prfl_pkg::POLICY_LRU);
        n_first = r_hit ? r_slot : '0;
        for (int k = 0; k < int'(MAX_FRAMES); k++) begin
            n_frame_page[k]  = r_frame_page[k];
            n_frame_valid[k] = r_frame_valid[k];
            if (n_shift && (k >= int'(n_first)) && (k + 1 < int'(n_active))) begin
                n_frame_page[k]  = r_frame_page[(k + 1) % MAX_FRAMES];
                n_frame_valid[k] = r_frame_valid[(k + 1) % MAX_FRAMES];
            end
            if (n_shift && (k == int'(n_active) - 1)) begin
                n_frame_page[k]  = r_page;
                n_frame_valid[k] = 1'b1;
            end
        end
        n_count = r_count;
        if (!r_hit && (r_count != prfl_pkg::COUNT_MAX)) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= prfl_pkg::POLICY_FIFO;
            r_frames <= prfl_pkg::FIU_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                prfl_pkg::CFG_POLICY_MODE: begin
                    r_policy <= prfl_pkg::t_policy'(i_cfg_data[0]);
                end
                prfl_pkg::CFG_FRAMES_IN_USE: begin
                    r_frames <= i_cfg_data[prfl_pkg::FIU_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= i_in.page_number[SW-1:0];
            r_last <= i_in.last_in_trace;
        end
        if (i_cmd.match) begin
            r_hit  <= n_hit;
            r_slot <= n_slot;
        end
        if (i_cmd.update) begin
            r_frame_page             <= n_frame_page;
            r_out.hit                <= r_hit;
            r_out.evicted_valid      <= !r_hit && r_frame_valid[0];
            r_out.evicted_page       <= (!r_hit && r_frame_valid[0])
                                        ? prfl_pkg::PAGE_W'(r_frame_page[0]) : '0;
            r_out.fault_total        <= n_count;
            r_out.trace_end          <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_frame_valid <= r_last ? '0 : n_frame_valid;
                r_count       <= r_last ? '0 : n_count;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out             = r_out;
    assign o_out_valid       = r_out_valid;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

>>> design/page_replacement_fifo_lru_core.sv
// FIFO and LRU page replacement engine. Each input beat is one page reference and yields
// one output beat with the hit flag, the evicted page, the running saturating fault count
// and an echo of the trace end mark; a beat marked last also empties all frames and clears
// the count. An item passes from input acceptance to a loaded output register in order:
// it is captured, compared against every frame in use in parallel, and then the frame row
// is shifted (on a miss, or on any hit under LRU) and the count updated, which waits while
// the output register holds a beat not yet taken. A new reference is taken only when the
// previous one has reached the output register. The user must write configuration
// through the plain write port only while the block is idle; the block itself does not
// enforce this. Index 0 selects the policy (0 FIFO, 1 LRU), index 1 sets the number of
// frames in use, where zero counts as one and values above MAX_FRAMES count as MAX_FRAMES.
`default_nettype none

module page_replacement_fifo_lru_core #(
    parameter int unsigned MAX_FRAMES = 16,
    parameter int unsigned PAGE_BITS  = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire prfl_pkg::t_in_beat         i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output prfl_pkg::t_out_beat             o_out,
    input  wire logic                       i_cfg_we,
    input  wire prfl_pkg::t_cfg_idx         i_cfg_idx,
    input  wire logic [prfl_pkg::CFG_W-1:0] i_cfg_data
);

    prfl_pkg::t_dp_cmd    cmd;
    prfl_pkg::t_dp_status status;

    prfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    prfl_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire

>>> design/prfl_checker.sv
`default_nettype none

module prfl_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire prfl_pkg::t_out_beat o_out
);

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input accepted while a reference is in flight.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("Output beat changed while stalled.");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.hit) |-> !o_out.evicted_valid)
        else $error("Hit reported an eviction.");

    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.evicted_valid) |-> (o_out.evicted_page == '0))
        else $error("Evicted page is nonzero without an eviction.");

    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.hit) |-> (o_out.fault_total != '0))
        else $error("Fault reported with a zero fault total.");

endmodule

bind page_replacement_fifo_lru_core prfl_checker u_prfl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
